// ----- rtl/ole_pkg.sv -----
// Package for the ordered list engine: operation and status codes, the
// sequencer states and the control bundle handed to every list cell.
// Depends on nothing; every other file refers to it by scoped names.
package ole_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Widths of the fixed transaction fields.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Number of positions an index field can address.
  localparam int INDEX_SPAN = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // Control broadcast to every cell of the list.
  typedef struct packed {
    logic cmp_en;    // register the compare result of each cell
    logic shift_en;  // cells at or after the first match take their neighbour's entry
    logic load_en;   // the cell just past the tail takes the key
  } cell_ctrl_t;

endpackage

// ----- rtl/ordered_list_engine.sv -----
// Ordered list engine: an insertion-ordered list of up to DEPTH values.
// Operands are registered on acceptance, match flags in the compare step, and the result
// in the output register once the update commits; no new transaction is taken before that.
// Reset: synchronous, active high; clears the entry count, sequencer and output valid.
// Depends on ole_pkg and ole_cell.
module ordered_list_engine #(
  parameter int DEPTH      = ole_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ole_pkg::OP_W-1:0]       op,
  input  logic signed [ole_pkg::VALUE_W-1:0] value,
  input  logic [ole_pkg::INDEX_W-1:0]    index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ole_pkg::STATUS_W-1:0]   status,
  output logic [ole_pkg::POS_W-1:0]      found_position,
  output logic signed [ole_pkg::VALUE_W-1:0] read_value,
  output logic [ole_pkg::COUNT_W-1:0]    entry_count
);

  // Width of the internal entry count, wide enough to hold DEPTH itself.
  localparam int CNT_W     = $clog2(DEPTH + 1);
  // Only the first positions of the list can be reached by the index field.
  localparam int READ_SPAN = (DEPTH < ole_pkg::INDEX_SPAN) ? DEPTH : ole_pkg::INDEX_SPAN;
  // Common width for comparing the index field against the count.
  localparam int CMP_W     = (CNT_W > ole_pkg::INDEX_W) ? CNT_W : ole_pkg::INDEX_W;

  // The sequencer walks each transaction through three steps. In the idle
  // state the operands are captured. In the compare state every cell
  // checks its own entry against the key at once. In the update state the
  // match flags ripple along the chain of cells to pick out the first
  // match, the result is formed, and the list is changed: on a removal
  // every cell from the match onwards takes its neighbour's entry, closing
  // the gap in one step, and on an append the cell just past the tail
  // takes the key. The update only commits when the output register is
  // free or being emptied in the same cycle, so a waiting result never
  // loses or repeats a transaction.
  ole_pkg::state_t state, state_next;

  ole_pkg::op_t            op_q;
  logic [DATA_WIDTH-1:0]   key_q;
  logic [ole_pkg::INDEX_W-1:0] index_q;
  logic [CNT_W-1:0]        count, count_next;

  ole_pkg::cell_ctrl_t     ctrl;
  logic                    accept;
  logic                    commit;

  logic [DATA_WIDTH-1:0]   entries [DEPTH];
  logic [DEPTH:0]          seen;
  logic [DEPTH-1:0]        first;

  logic                    any_match;
  logic [ole_pkg::POS_W-1:0] first_pos;
  logic [DATA_WIDTH-1:0]   rd_word;
  logic                    full;
  logic                    index_ok;

  ole_pkg::status_t        status_next;
  logic [ole_pkg::POS_W-1:0] pos_next;
  logic signed [ole_pkg::VALUE_W-1:0] read_next;

  assign in_stall = (state != ole_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == ole_pkg::ST_UPD) && (!out_valid || !out_stall);

  // Operand capture. The value is sign-extended or cut to the stored width.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= ole_pkg::op_t'(op);
      key_q   <= DATA_WIDTH'(value);
      index_q <= index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.cmp_en   = 1'b0;
    ctrl.shift_en = 1'b0;
    ctrl.load_en  = 1'b0;
    unique case (state)
      ole_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ole_pkg::ST_CMP;
        end
      end
      ole_pkg::ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_next  = ole_pkg::ST_UPD;
      end
      ole_pkg::ST_UPD: begin
        if (commit) begin
          ctrl.shift_en = (op_q == ole_pkg::OP_REMOVE) && any_match;
          ctrl.load_en  = (op_q == ole_pkg::OP_APPEND) && !full;
          state_next    = ole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ole_pkg::ST_IDLE;
      end
    endcase
  end

  // The row of cells. Each cell hands its entry towards the head on a
  // removal and passes the "match seen already" flag towards the tail.
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] next_entry;

    if (g == DEPTH - 1) begin : g_last
      assign next_entry = entries[g];
    end else begin : g_inner
      assign next_entry = entries[g + 1];
    end

    ole_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key_q),
      .occupied   (CNT_W'(g) < count),
      .load_sel   (CNT_W'(g) == count),
      .next_entry (next_entry),
      .before_in  (seen[g]),
      .before_out (seen[g + 1]),
      .first      (first[g]),
      .entry      (entries[g])
    );
  end

  assign any_match = seen[DEPTH];

  // At most one cell flags the first match, so its position is an OR.
  always_comb begin
    first_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        first_pos = first_pos | ole_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < READ_SPAN; i++) begin
      if (ole_pkg::INDEX_W'(i) == index_q) begin
        rd_word = entries[i];
      end
    end
  end

  assign full     = (count == CNT_W'(DEPTH));
  assign index_ok = CMP_W'(index_q) < CMP_W'(count);

  // Result and new count for the transaction in the update step.
  always_comb begin
    status_next = ole_pkg::STATUS_OK;
    pos_next    = '0;
    read_next   = '0;
    count_next  = count;
    case (op_q) inside
      ole_pkg::OP_APPEND: begin
        if (full) begin
          status_next = ole_pkg::STATUS_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ole_pkg::OP_REMOVE, ole_pkg::OP_FIND: begin
        if (!any_match) begin
          status_next = ole_pkg::STATUS_NOT_FOUND;
        end else begin
          pos_next = first_pos;
          if (op_q == ole_pkg::OP_REMOVE) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        if (index_ok) begin
          read_next = ole_pkg::VALUE_W'(signed'(rd_word));
        end else begin
          status_next = ole_pkg::STATUS_BAD_INDEX;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register: holds a finished result until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= status_next;
      found_position <= pos_next;
      read_value     <= read_next;
      entry_count    <= ole_pkg::COUNT_W'(count_next);
    end
  end

endmodule

// ----- rtl/ole_cell.sv -----
// One cell of the ordered list: one stored entry, its match flag and its
// link in the first-match chain. Depends on ole_pkg.
module ole_cell #(
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  ole_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  key,
  input  logic                   occupied,
  input  logic                   load_sel,
  input  logic [DATA_WIDTH-1:0]  next_entry,
  input  logic                   before_in,
  output logic                   before_out,
  output logic                   first,
  output logic [DATA_WIDTH-1:0]  entry
);

  logic match;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= occupied && (entry == key);
    end
    if (ctrl.load_en && load_sel) begin
      entry <= key;
    end else if (ctrl.shift_en && (match || before_in)) begin
      entry <= next_entry;
    end
  end

  // A match further towards the head wins; this cell passes that on.
  assign before_out = before_in | match;
  assign first      = match & ~before_in;

endmodule

// ----- verif/tb_ordered_list_engine.sv -----
// Self-checking testbench for ordered_list_engine: a shadow list predicts each result.
// Depends on ole_pkg for the operation and status codes and on the engine RTL itself.
// Stimulus is driven at the falling edge and results are sampled at the rising edge.
module tb_ordered_list_engine;

  localparam int LIST_DEPTH  = 16;
  localparam int LONG_HOLD   = 80;  // cycles the receiver holds off in the pressure test
  localparam int SETTLE_WAIT = 12;  // settling time after the final drain

  // One predicted result, field for field as the engine presents it.
  typedef struct {
    ole_pkg::status_t                     code;
    logic [ole_pkg::POS_W-1:0]            position;
    logic signed [ole_pkg::VALUE_W-1:0]   word;
    logic [ole_pkg::COUNT_W-1:0]          count;
  } list_result_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [ole_pkg::OP_W-1:0]             op;
  logic signed [ole_pkg::VALUE_W-1:0]   value;
  logic [ole_pkg::INDEX_W-1:0]          index;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [ole_pkg::STATUS_W-1:0]         status;
  logic [ole_pkg::POS_W-1:0]            found_position;
  logic signed [ole_pkg::VALUE_W-1:0]   read_value;
  logic [ole_pkg::COUNT_W-1:0]          entry_count;

  // The shadow copy of the list, kept in step with every accepted transaction.
  logic signed [ole_pkg::VALUE_W-1:0]   shadow_list [LIST_DEPTH];
  int                                   shadow_fill;

  list_result_t                         pending_results [$];

  // Knobs shared between the test tasks and the idling processes.
  int gap_pct;        // chance, in percent, that the sender idles after a transaction
  int stall_pct;      // chance, in percent, that the receiver starts a stall on a cycle
  int hold_request;   // non-zero asks the receiver for one long hold of that many cycles

  int items_sent;
  int results_checked;
  int mismatches;
  int status_tally [4];

  ordered_list_engine dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .value          (value),
    .index          (index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .read_value     (read_value),
    .entry_count    (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one operation to the shadow list and returns the result the engine owes.
  // Removal closes the gap so that the order of the survivors is kept.
  function automatic list_result_t list_apply(ole_pkg::op_t kind,
                                              logic signed [ole_pkg::VALUE_W-1:0] key,
                                              logic [ole_pkg::INDEX_W-1:0] where);
    list_result_t r;
    int           hit;
    r.code     = ole_pkg::STATUS_OK;
    r.position = '0;
    r.word     = '0;
    hit        = shadow_fill;
    if (kind == ole_pkg::OP_REMOVE || kind == ole_pkg::OP_FIND) begin
      for (int i = shadow_fill - 1; i >= 0; i--) begin
        if (shadow_list[i] == key) hit = i;
      end
    end
    case (kind) inside
      ole_pkg::OP_APPEND: begin
        if (shadow_fill >= LIST_DEPTH) begin
          r.code = ole_pkg::STATUS_FULL;
        end else begin
          shadow_list[shadow_fill] = key;
          shadow_fill++;
        end
      end
      ole_pkg::OP_REMOVE, ole_pkg::OP_FIND: begin
        if (hit >= shadow_fill) begin
          r.code = ole_pkg::STATUS_NOT_FOUND;
        end else begin
          r.position = hit[ole_pkg::POS_W-1:0];
          if (kind == ole_pkg::OP_REMOVE) begin
            for (int i = hit; i < shadow_fill - 1; i++) shadow_list[i] = shadow_list[i + 1];
            shadow_fill--;
          end
        end
      end
      default: begin
        if (where >= shadow_fill) r.code = ole_pkg::STATUS_BAD_INDEX;
        else r.word = shadow_list[where];
      end
    endcase
    r.count = shadow_fill[ole_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [ole_pkg::VALUE_W-1:0] boundary_value(int k);
    case (k)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  // A value that hits the list with the given chance, otherwise a boundary or fresh word.
  function automatic logic signed [ole_pkg::VALUE_W-1:0] pick_value(int hit_pct);
    if (shadow_fill > 0 && $urandom_range(0, 99) < hit_pct)
      return shadow_list[$urandom_range(0, shadow_fill - 1)];
    if ($urandom_range(0, 9) == 0) return boundary_value($urandom_range(0, 4));
    return $urandom;
  endfunction

  // Offers one transaction and holds it until the engine takes it, then predicts its result.
  task automatic send_op(ole_pkg::op_t kind, logic signed [ole_pkg::VALUE_W-1:0] key,
                         logic [ole_pkg::INDEX_W-1:0] where);
    list_result_t want;
    @(negedge clk);
    in_valid = 1'b1;
    op       = kind;
    value    = key;
    index    = where;
    do @(posedge clk); while (in_stall);
    want = list_apply(kind, key, where);
    status_tally[want.code]++;
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Drops valid for the given number of cycles; zero keeps the stream back to back.
  task automatic sender_idle(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Waits until every predicted result has been collected.
  task automatic wait_for_drain();
    sender_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random operations; the append and remove weights steer the list towards full or empty.
  task automatic run_random_ops(int count, int append_w, int remove_w);
    int           r;
    ole_pkg::op_t kind;
    logic [ole_pkg::INDEX_W-1:0] where;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < append_w) kind = ole_pkg::OP_APPEND;
      else if (r < append_w + remove_w) kind = ole_pkg::OP_REMOVE;
      else if (r < append_w + remove_w + (100 - append_w - remove_w) / 2)
        kind = ole_pkg::OP_FIND;
      else kind = ole_pkg::OP_READ;
      if (shadow_fill > 0 && $urandom_range(0, 9) < 7) where = $urandom_range(0, shadow_fill - 1);
      else where = $urandom_range(0, LIST_DEPTH - 1);
      send_op(kind, pick_value(kind == ole_pkg::OP_APPEND ? 15 : 70), where);
      sender_idle(idle_length(gap_pct));
    end
  endtask

  // Empty-list misses, a fill to the brim with duplicates and boundary values, a refused
  // append, a tail read and a find, then removals from the middle and head and a head read.
  task automatic test_corner_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_op(ole_pkg::OP_READ,   '0, 4'd0);
    send_op(ole_pkg::OP_FIND,   32'sd7, '0);
    send_op(ole_pkg::OP_REMOVE, 32'sd7, '0);
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (i < 4) send_op(ole_pkg::OP_APPEND, boundary_value(i), '0);
      else if (i < 6) send_op(ole_pkg::OP_APPEND, 32'sd7, '0);
      else send_op(ole_pkg::OP_APPEND, $urandom, '0);
    end
    send_op(ole_pkg::OP_APPEND, 32'sd99, '0);
    send_op(ole_pkg::OP_READ,   '0, 4'd15);
    send_op(ole_pkg::OP_FIND,   32'sd7, '0);
    send_op(ole_pkg::OP_REMOVE, 32'sd7, '0);
    send_op(ole_pkg::OP_REMOVE, 32'sh8000_0000, '0);
    send_op(ole_pkg::OP_READ,   '0, 4'd0);
    wait_for_drain();
  endtask

  // Grows the list so that appends often meet a full list.
  task automatic test_grow_traffic();
    gap_pct   = 30;
    stall_pct = 25;
    run_random_ops(300, 50, 20);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // engine fills its output and has to stall its input.
  task automatic test_receiver_hold();
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = LONG_HOLD;
    run_random_ops(24, 35, 30);
  endtask

  // The sender stops and lets every outstanding result come home before going on.
  task automatic test_drain_pause();
    wait_for_drain();
  endtask

  // Shrinks the list so that removals and finds often miss on a short or empty list.
  task automatic test_shrink_traffic();
    gap_pct   = 30;
    stall_pct = 25;
    run_random_ops(250, 20, 45);
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    run_random_ops(100, 35, 30);
  endtask

  // A balanced mix with heavy idling on both sides.
  task automatic test_mixed_traffic();
    gap_pct   = 45;
    stall_pct = 40;
    run_random_ops(250, 35, 30);
  endtask

  // Receiver side: random stalls of mostly short and occasionally long length, plus the
  // one long hold that the pressure test asks for, counted out here cycle by cycle.
  initial begin : receiver_stall
    int run_left;
    int held;
    out_stall = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall = 1'b1;
        held      = 0;
        while (held < hold_request) begin
          @(negedge clk);
          held++;
        end
        hold_request = 0;
        out_stall    = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_stall = 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        run_left  = idle_length(100) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic note_failure(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Every result taken from the engine is matched against the oldest prediction.
  initial begin : result_checker
    list_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result status=%0d pos=%0d read=%0d count=%0d",
                                 status, found_position, read_value, entry_count));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (status !== want.code || found_position !== want.position ||
              read_value !== want.word || entry_count !== want.count) begin
            note_failure($sformatf(
              "expected status=%0d pos=%0d read=%0d count=%0d, got %0d %0d %0d %0d",
              want.code, want.position, want.word, want.count,
              status, found_position, read_value, entry_count));
          end
        end
      end
    end
  end

  // Hard stop in case the engine hangs.
  initial begin : watchdog
    #2000000;
    $display("ordered_list_engine verification failed");
    $finish;
  end

  initial begin : test_sequence
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = ole_pkg::OP_APPEND;
    value        = '0;
    index        = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 0;
    shadow_fill  = 0;
    items_sent   = 0;
    results_checked = 0;
    mismatches   = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (shadow_list[i]) shadow_list[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_cases();
    test_grow_traffic();
    test_receiver_hold();
    test_drain_pause();
    test_shrink_traffic();
    test_back_to_back();
    test_mixed_traffic();

    wait_for_drain();
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Covered %0d transactions with %0d results checked and %0d mismatches.",
             items_sent, results_checked, mismatches);
    $display("Status mix: ok %0d, full %0d, not found %0d, index beyond count %0d.",
             status_tally[ole_pkg::STATUS_OK], status_tally[ole_pkg::STATUS_FULL],
             status_tally[ole_pkg::STATUS_NOT_FOUND], status_tally[ole_pkg::STATUS_BAD_INDEX]);
    if (mismatches == 0) begin
      $display("ordered_list_engine verification clean");
    end else begin
      $display("ordered_list_engine verification failed");
    end
    $finish;
  end

endmodule
